// ===== rtl/set_assoc_cache_lru_tags_macros.svh =====
// assertion macros for the lru tag store
`ifndef SET_ASSOC_CACHE_LRU_TAGS_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_MACROS_SVH
`ifndef ASSERT_OFF
`define SCL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SCL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SCL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/scl_pkg.sv =====
// ------------------------------------------------------------------
// scl_pkg
// shared types and constants of the lru tag store
// ------------------------------------------------------------------
package scl_pkg;
	localparam int WAYS = 8;
	localparam int MAX_SET_BITS = 6;
	localparam int ADDR_BITS = 48;
	localparam int OUT_BITS = 48;
	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W = $clog2(WAYS + 1);
	localparam int LINE_W = 1 + ADDR_BITS + 32;

	typedef enum logic [1:0] {
		REG_BLOCK_BITS = 2'd0,
		REG_SET_BITS   = 2'd1,
		REG_WAYS       = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_FILL  = 2'd1,
		ST_EVICT = 2'd2,
		ST_FLUSH = 2'd3
	} status_t;

	typedef struct packed {
		logic                  valid;
		logic [ADDR_BITS-1:0]  tag;
		logic [31:0]           stamp;
	} line_t;

	typedef struct packed {
		logic [4:0]            bb;
		logic [2:0]            sb;
		logic [WCNT_W-1:0]     nw;
	} cfg_t;

	// request word
	typedef struct packed {
		logic                 op;
		logic [ADDR_BITS-1:0] address;
	} request_t;

	// result word
	typedef struct packed {
		status_t              status;
		logic [OUT_BITS-1:0]  evict_blk;
		logic [OUT_BITS-1:0]  fill_blk;
		logic                 flush_removed;
		logic [31:0]          hits_total;
		logic [31:0]          misses_total;
		logic [31:0]          evictions_total;
	} result_t;
endpackage

// ===== rtl/scl_stream_if.sv =====
// ------------------------------------------------------------------
// scl_stream_if
// valid/ready channel carrying one word of payload
// ------------------------------------------------------------------
interface scl_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/scl_set_ram.sv =====
// ------------------------------------------------------------------
// scl_set_ram
// one row per set holding all ways, registered read, written flag per set
// ------------------------------------------------------------------
module scl_set_ram (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [scl_pkg::SET_W-1:0]           rd_addr,
	output scl_pkg::line_t [scl_pkg::WAYS-1:0]  rd_data,
	input  logic                                wr_en,
	input  logic [scl_pkg::SET_W-1:0]           wr_addr,
	input  scl_pkg::line_t [scl_pkg::WAYS-1:0]  wr_data
);
	import scl_pkg::*;

	logic [LINE_W-1:0] mem [SETS][WAYS];
	logic [SETS-1:0]   row_ok_q;
	logic [LINE_W-1:0] rd_q [WAYS];
	logic              rd_ok_q;

	// line rows, valid bit stored with tag and stamp
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int w = 0; w < WAYS; w++)
				mem[wr_addr][w] <= wr_data[w];
		end
		if (rd_en) begin
			for (int w = 0; w < WAYS; w++)
				rd_q[w] <= mem[rd_addr][w];
		end
	end

	// a set never written since reset reads as all ways invalid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) row_ok_q[wr_addr] <= 1'b1;
			if (rd_en) rd_ok_q <= row_ok_q[rd_addr];
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			rd_data[w] = line_t'(rd_q[w]);
			rd_data[w].valid = rd_q[w][LINE_W-1] & rd_ok_q;
		end
	end
endmodule

// ===== rtl/scl_lookup.sv =====
// ------------------------------------------------------------------
// scl_lookup
// way compare, free way search and lru victim select over one set
// ------------------------------------------------------------------
module scl_lookup (
	input  scl_pkg::line_t [scl_pkg::WAYS-1:0] lines,
	input  logic [scl_pkg::ADDR_BITS-1:0]      tag,
	input  logic [scl_pkg::WCNT_W-1:0]         nw,
	output logic                               hit,
	output logic [scl_pkg::WAY_W-1:0]          hit_way,
	output logic                               free,
	output logic [scl_pkg::WAY_W-1:0]          free_way,
	output logic [scl_pkg::WAY_W-1:0]          lru_way
);
	import scl_pkg::*;

	logic [31:0] best_stamp;

	// first matching and first free way
	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		free = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (WCNT_W'(w) < nw) begin
				if (lines[w].valid && lines[w].tag == tag) begin
					hit = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!lines[w].valid) begin
					free = 1'b1;
					free_way = WAY_W'(w);
				end
			end
		end
	end

	// oldest stamp, lowest way on a tie
	always_comb begin
		lru_way = '0;
		best_stamp = lines[0].stamp;
		for (int w = 1; w < WAYS; w++) begin
			if (WCNT_W'(w) < nw && lines[w].stamp < best_stamp) begin
				best_stamp = lines[w].stamp;
				lru_way = WAY_W'(w);
			end
		end
	end
endmodule

// ===== rtl/set_assoc_cache_lru_tags.sv =====
// a word accepted has its set read, then is compared and written back, and
// its result is registered; no new word is taken until its set is written back
// a new word waits while a set is in work or an unaccepted result is held
// reset: written flags, counters and configuration cleared to defaults at once
// ------------------------------------------------------------------
// set_assoc_cache_lru_tags
// tag store of a set-associative cache with lru replacement
// ------------------------------------------------------------------
module set_assoc_cache_lru_tags (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	scl_stream_if.sink   in_ch,
	scl_stream_if.source out_ch
);
	import scl_pkg::*;
	`include "set_assoc_cache_lru_tags_macros.svh"

	logic [4:0]  bb_q;
	logic [2:0]  sb_q;
	logic [3:0]  nw_q;
	logic [WCNT_W-1:0] nw_eff;
	logic [2:0]  sb_eff;

	logic busy_s1;
	logic op_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic [SET_W-1:0] set_s1;

	logic [31:0] acc_q, hits_q, miss_q, evic_q;
	logic        ovld_q;
	status_t     res_st_q;
	logic [OUT_BITS-1:0] res_evict_q, res_fill_q;
	logic        res_removed_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q <= 5'd4;
			sb_q <= 3'd6;
			nw_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BLOCK_BITS: bb_q <= cfg_data;
				REG_SET_BITS:   sb_q <= cfg_data[2:0];
				REG_WAYS:       nw_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sb_eff = (32'(sb_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : sb_q;
		if (nw_q == 4'd0) nw_eff = WCNT_W'(1);
		else if (32'(nw_q) > WAYS) nw_eff = WCNT_W'(WAYS);
		else nw_eff = WCNT_W'(nw_q);
	end

	// address split
	logic [ADDR_BITS-1:0] in_addr;
	logic [6:0] shift;
	logic [ADDR_BITS-1:0] tag_in;
	logic [ADDR_BITS-1:0] set_full;
	logic [SET_W-1:0] set_in;
	assign in_addr = in_ch.data.address;
	assign shift = 7'(bb_q) + 7'(sb_eff);
	assign tag_in = (shift >= 7'd64) ? '0 : ADDR_BITS'(64'(in_addr) >> shift);
	assign set_full = (in_addr >> bb_q) & ((ADDR_BITS'(1) << sb_eff) - ADDR_BITS'(1));
	assign set_in = SET_W'(set_full);

	logic take;
	assign in_ch.ready = !busy_s1 && !(ovld_q && !out_ch.ready);
	assign take = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_s1 <= 1'b0;
		else busy_s1 <= take;
	end
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= in_ch.data.op;
			tag_s1 <= tag_in;
			set_s1 <= set_in;
		end
	end

	line_t [WAYS-1:0] rd_lines, wr_lines;
	logic wr_en;

	scl_set_ram u_ram (
		.clk(clk), .arst_n(arst_n),
		.rd_en(take), .rd_addr(set_in), .rd_data(rd_lines),
		.wr_en(wr_en), .wr_addr(set_s1), .wr_data(wr_lines)
	);

	logic hit, free;
	logic [WAY_W-1:0] hit_way, free_way, lru_way;
	scl_lookup u_lookup (
		.lines(rd_lines), .tag(tag_s1), .nw(nw_eff),
		.hit(hit), .hit_way(hit_way), .free(free), .free_way(free_way),
		.lru_way(lru_way)
	);

	// decide and write back
	logic [31:0] acc_nx;
	logic [WAY_W-1:0] way;
	status_t st;
	logic [ADDR_BITS-1:0] blk, vblk, set_sh;
	logic [6:0] shift2;
	logic removed;
	logic [WCNT_W-1:0] rem_cnt;
	assign acc_nx = acc_q + 32'd1;
	assign shift2 = 7'(bb_q) + 7'(sb_eff);
	assign set_sh = ADDR_BITS'(set_s1) << bb_q;
	always_comb begin
		wr_lines = rd_lines;
		rem_cnt = '0;
		way = '0;
		st = ST_FLUSH;
		if (op_s1) begin
			// every matching line in use is dropped and counted
			for (int w = 0; w < WAYS; w++) begin
				if (WCNT_W'(w) < nw_eff && rd_lines[w].valid && rd_lines[w].tag == tag_s1) begin
					wr_lines[w].valid = 1'b0;
					rem_cnt = rem_cnt + WCNT_W'(1);
				end
			end
		end else begin
			if (hit) begin way = hit_way; st = ST_HIT; end
			else if (free) begin way = free_way; st = ST_FILL; end
			else begin way = lru_way; st = ST_EVICT; end
			wr_lines[way].valid = 1'b1;
			wr_lines[way].tag = tag_s1;
			wr_lines[way].stamp = acc_nx;
		end
		removed = (rem_cnt != '0);
		blk = ((shift2 >= 7'd64) ? '0 : ADDR_BITS'(64'(tag_s1) << shift2)) + set_sh;
		vblk = ((shift2 >= 7'd64) ? '0 : ADDR_BITS'(64'(rd_lines[lru_way].tag) << shift2))
			+ set_sh;
	end
	assign wr_en = busy_s1;

	// counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; hits_q <= '0; miss_q <= '0; evic_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (out_ch.ready) ovld_q <= 1'b0;
			if (busy_s1) begin
				ovld_q <= 1'b1;
				if (op_s1) begin
					evic_q <= evic_q + 32'(rem_cnt);
				end else begin
					acc_q <= acc_nx;
					if (st == ST_HIT) hits_q <= hits_q + 32'd1;
					else miss_q <= miss_q + 32'd1;
					if (st == ST_EVICT) evic_q <= evic_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			res_st_q <= st;
			res_evict_q <= (st == ST_EVICT) ? vblk : '0;
			res_fill_q <= (st == ST_FILL || st == ST_EVICT) ? blk : '0;
			res_removed_q <= removed;
		end
	end
	assign out_ch.valid = ovld_q;
	assign out_ch.data = result_t'{
		status: res_st_q,
		evict_blk: res_evict_q,
		fill_blk: res_fill_q,
		flush_removed: res_removed_q,
		hits_total: hits_q,
		misses_total: miss_q,
		evictions_total: evic_q
	};

	`SCL_ASSERT_NXT(a_result_follows, clk, arst_n, busy_s1, ovld_q)
	`SCL_ASSERT_IMP(a_no_take_busy, clk, arst_n, busy_s1, !take)
	`SCL_ASSERT_NXT(a_acc_hold_flush, clk, arst_n, busy_s1 && op_s1, $stable(acc_q))
endmodule
